FILE: rtl/deks_pkg.sv
// Package for the DES expansion, key mixing and S-box unit.
// Holds the field widths, the E selection table, the eight S-boxes and the lookup functions.
// Has no dependencies; the top level imports it.
package deks_pkg;

	localparam int unsigned HALF_W     = 32;
	localparam int unsigned KEY_W      = 48;
	localparam int unsigned SBOX_OUT_W = 32;
	localparam int unsigned NUM_BOXES  = 8;
	localparam int unsigned BOX_IN_W   = 6;
	localparam int unsigned BOX_OUT_W  = 4;
	localparam int unsigned BOX_DEPTH  = 64;

	// Stream payload widths, padded up to whole bytes.
	localparam int unsigned IN_DATA_BITS = HALF_W + KEY_W;
	localparam int unsigned IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W  = ((SBOX_OUT_W + 7) / 8) * 8;

	typedef logic [HALF_W-1:0]     half_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [SBOX_OUT_W-1:0] sbox_word_t;
	typedef logic [BOX_IN_W-1:0]   six_t;
	typedef logic [BOX_OUT_W-1:0]  nib_t;
	typedef logic [5:0]            esel_t;

	// Source bit of the half block for each expanded position, one based, DES order.
	localparam esel_t ESEL [KEY_W] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
		6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
		6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	// Each box is laid out as row * 16 + column.
	localparam nib_t SBOX [NUM_BOXES][BOX_DEPTH] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
	};

	// E expansion: position p in DES order lands in bit KEY_W-1-p of the result.
	function automatic key_t deks_expand(input half_t half);
		key_t  acc;
		esel_t src;
		acc = '0;
		for (int p = 0; p < KEY_W; p++) begin
			src = esel_t'(HALF_W) - ESEL[p];
			acc[KEY_W-1-p] = half[src[4:0]];
		end
		return acc;
	endfunction

	// Full substitution of a mixed 48-bit word; box 1 takes the top group.
	function automatic sbox_word_t deks_substitute(input key_t mixed);
		sbox_word_t res;
		six_t       six;
		for (int b = 0; b < NUM_BOXES; b++) begin
			six = mixed[KEY_W-1-BOX_IN_W*b -: BOX_IN_W];
			// Row comes from the outer bits, column from the middle four.
			res[SBOX_OUT_W-1-BOX_OUT_W*b -: BOX_OUT_W] = SBOX[b][{six[5], six[0], six[4:1]}];
		end
		return res;
	endfunction

endpackage

FILE: rtl/des_expand_keymix_sbox_unit.sv
// DES round core without the P permutation: E expansion, key XOR and the eight S-boxes.
// Depends on deks_pkg for widths, tables and the lookup functions.
//
//  Channel   Dir  Handshake                Payload
//  s_axis    in   s_axis_tvalid/tready     tdata[31:0] half_block, [79:32] round_key
//  m_axis    out  m_axis_tvalid/tready     tdata[31:0] sbox_out
//
// Each transaction passes an input register and then a result register; the lookup logic
// between them is one XOR level and eight 64-entry table reads. One transaction is taken
// every cycle while the output side keeps up. Under output back-pressure the two registers
// fill and the input stalls only when both hold data. Reset clears the valid flags only;
// payloads are not reset.
module des_expand_keymix_sbox_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0 up: half_block [31:0], round_key [79:32].
	input  logic [deks_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0 up: sbox_out [31:0].
	output logic [deks_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import deks_pkg::*;

	logic       valid_s1;
	half_t      half_s1;
	key_t       key_s1;
	logic       valid_s2;
	sbox_word_t result_s2;
	sbox_word_t result_next;
	logic       load_s2;
	logic       load_s1;

	// The result register takes a new word when it is empty or is being drained.
	assign load_s2       = valid_s1 && (!valid_s2 || m_axis_tready);
	// The input register frees up when it is empty or its content moves on.
	assign s_axis_tready = !valid_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	// Expansion and key mixing feed straight into the S-box lookups.
	assign result_next = deks_substitute(deks_expand(half_s1) ^ key_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (!valid_s2 || m_axis_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			half_s1 <= s_axis_tdata[HALF_W-1:0];
			key_s1  <= s_axis_tdata[HALF_W +: KEY_W];
		end
		if (load_s2) begin
			result_s2 <= result_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(result_s2);

`ifndef SYNTHESIS
	// An accepted transaction always lands in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted transaction did not reach the input register");

	// A held input register keeps its operands.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(half_s1) && $stable(key_s1))
		else $error("stalled operands changed");

	// The lookup result moves to the output on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> m_axis_tvalid && (result_s2 == $past(result_next)))
		else $error("result register did not capture the lookup");

	// The input side only stalls when both registers are full and the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled without back-pressure");
`endif

endmodule
